### rtl/core/dkrm_pkg.sv
package dkrm_pkg;

    localparam int CH_W     = 8;
    localparam int NUM_CH   = 4;
    localparam int CH_ALPHA = 3;

    localparam logic [CH_W-1:0] CHAN_MAX   = 8'd255;
    localparam logic [15:0]     FULL_SCALE = 16'd65025;
    localparam logic [16:0]     FRAC_ONE   = 17'd65536;

    localparam int INV_W   = 22;
    localparam int DEPTH_W = 16;
    localparam int ADDR_W  = 4;

    localparam logic [1:0] REG_INV_OVERLAP = 2'd0;
    localparam logic [1:0] REG_DEPTH_OFF   = 2'd1;
    localparam logic [1:0] REG_SCALE_ONE   = 2'd2;
    localparam logic [1:0] REG_SCALE_TWO   = 2'd3;

    localparam logic [INV_W-1:0]   INV_RESET   = 22'd4112063;
    localparam logic [DEPTH_W-1:0] OFF_RESET   = 16'd0;
    localparam logic [DEPTH_W-1:0] SCALE_RESET = 16'd16384;

    typedef logic [NUM_CH-1:0][CH_W-1:0] rgba_t;

    typedef struct packed {
        logic [INV_W-1:0]   inv_overlap_scale;
        logic [DEPTH_W-1:0] depth_offset;
        logic [DEPTH_W-1:0] depth_scale_one;
        logic [DEPTH_W-1:0] depth_scale_two;
    } cfg_t;

endpackage

### rtl/core/dkrm_cfg.sv
module dkrm_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dkrm_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output dkrm_pkg::cfg_t               cfg
);
    import dkrm_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] idx;

    assign idx    = paddr[3:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_INV_OVERLAP: cfg_next.inv_overlap_scale = pwdata[INV_W-1:0];
                REG_DEPTH_OFF:   cfg_next.depth_offset      = pwdata[DEPTH_W-1:0];
                REG_SCALE_ONE:   cfg_next.depth_scale_one   = pwdata[DEPTH_W-1:0];
                REG_SCALE_TWO:   cfg_next.depth_scale_two   = pwdata[DEPTH_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_INV_OVERLAP: prdata = {10'd0, cfg_reg.inv_overlap_scale};
            REG_DEPTH_OFF:   prdata = {{16{cfg_reg.depth_offset[15]}}, cfg_reg.depth_offset};
            REG_SCALE_ONE:
                prdata = {{16{cfg_reg.depth_scale_one[15]}}, cfg_reg.depth_scale_one};
            REG_SCALE_TWO:
                prdata = {{16{cfg_reg.depth_scale_two[15]}}, cfg_reg.depth_scale_two};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_overlap_scale <= INV_RESET;
            cfg_reg.depth_offset      <= OFF_RESET;
            cfg_reg.depth_scale_one   <= SCALE_RESET;
            cfg_reg.depth_scale_two   <= SCALE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/core/dkrm_weight.sv
module dkrm_weight (
    input  logic                        clk,
    input  dkrm_pkg::cfg_t              cfg,
    input  logic [dkrm_pkg::CH_W-1:0]   depth_one,
    input  logic [dkrm_pkg::CH_W-1:0]   depth_two,
    output logic [16:0]                 frac
);
    import dkrm_pkg::*;

    // stage 1: depth products
    logic signed [24:0] pa_reg, pa_next;
    logic signed [24:0] pb_reg, pb_next;
    logic signed [24:0] off_reg, off_next;
    // stage 2: difference, 14 fraction bits
    logic signed [26:0] diff_reg, diff_next;
    // stage 3: times reciprocal, 35 fraction bits
    logic signed [49:0] prod_reg, prod_next;
    // stage 4: weight in Q1.16
    logic [16:0]        frac_reg, frac_next;

    logic signed [15:0] off_s;
    logic signed [50:0] t_val;
    logic [31:0]        f_raw;

    assign off_s = $signed(cfg.depth_offset);

    always_comb
    begin
        pa_next  = 25'($signed({1'b0, depth_two})) * 25'($signed(cfg.depth_scale_two));
        pb_next  = 25'($signed({1'b0, depth_one})) * 25'($signed(cfg.depth_scale_one));
        // offset * 255 as offset * 256 - offset
        off_next = 25'($signed({off_s, 8'd0})) - 25'(off_s);
        diff_next = 27'(pa_reg) - 27'(pb_reg) - 27'(off_reg);
        prod_next = 50'(diff_reg) * 50'($signed({1'b0, cfg.inv_overlap_scale}));
        t_val     = 51'(prod_reg) + (51'sd1 <<< 34);
        f_raw     = 32'(t_val >>> 19);
        if (t_val <= 51'sd0)
        begin
            frac_next = 17'd0;
        end
        else if (f_raw > 32'(FRAC_ONE))
        begin
            frac_next = FRAC_ONE;
        end
        else
        begin
            frac_next = f_raw[16:0];
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        off_reg  <= off_next;
        diff_reg <= diff_next;
        prod_reg <= prod_next;
        frac_reg <= frac_next;
    end

    assign frac = frac_reg;

endmodule

### rtl/core/dkrm_comp.sv
module dkrm_comp (
    input  logic            clk,
    input  dkrm_pkg::rgba_t pix1,
    input  dkrm_pkg::rgba_t pix2,
    input  logic [16:0]     frac,
    output dkrm_pkg::rgba_t pix_out
);
    import dkrm_pkg::*;

    logic [NUM_CH-1:0][15:0] top1_reg, top2_reg, bot1_reg, bot2_reg;
    logic [NUM_CH-1:0][15:0] top1_next, top2_next, bot1_next, bot2_next;
    logic [NUM_CH-1:0][15:0] c1_reg, c2_reg, c1_next, c2_next;
    logic [NUM_CH-1:0][15:0] c1_d3_reg, c2_d3_reg, c1_d4_reg, c2_d4_reg;
    logic [NUM_CH-1:0][32:0] m1_reg, m2_reg, m1_next, m2_next;
    rgba_t                   out_reg, out_next;

    logic [CH_W-1:0] a1, a2;
    logic [16:0]     frac_inv;

    assign a1       = pix1[CH_ALPHA];
    assign a2       = pix2[CH_ALPHA];
    assign frac_inv = FRAC_ONE - frac;

    always_comb
    begin
        logic [33:0] s;
        logic [17:0] v;
        logic [15:0] vc;
        logic [16:0] q;
        s  = '0;
        v  = '0;
        vc = '0;
        q  = '0;
        for (int k = 0; k < NUM_CH; k++)
        begin
            if (k == CH_ALPHA)
            begin
                top1_next[k] = 16'(a1) * 16'(CHAN_MAX);
                top2_next[k] = 16'(a2) * 16'(CHAN_MAX);
            end
            else
            begin
                top1_next[k] = 16'(a1) * 16'(pix1[k]);
                top2_next[k] = 16'(a2) * 16'(pix2[k]);
            end
            bot1_next[k] = 16'(CHAN_MAX - a1) * 16'(pix2[k]);
            bot2_next[k] = 16'(CHAN_MAX - a2) * 16'(pix1[k]);
            c1_next[k]   = top1_reg[k] + bot1_reg[k];
            c2_next[k]   = top2_reg[k] + bot2_reg[k];
            m1_next[k]   = 33'(frac) * 33'(c1_d4_reg[k]);
            m2_next[k]   = 33'(frac_inv) * 33'(c2_d4_reg[k]);
            s  = 34'(m1_reg[k]) + 34'(m2_reg[k]);
            v  = s[33:16];
            vc = (v > 18'(FULL_SCALE)) ? FULL_SCALE : v[15:0];
            // divide by 255
            q  = (17'(vc) + 17'(vc[15:8]) + 17'd1);
            out_next[k] = (q[16:8] > 9'(CHAN_MAX)) ? CHAN_MAX : q[15:8];
        end
    end

    always_ff @(posedge clk)
    begin
        top1_reg  <= top1_next;
        top2_reg  <= top2_next;
        bot1_reg  <= bot1_next;
        bot2_reg  <= bot2_next;
        c1_reg    <= c1_next;
        c2_reg    <= c2_next;
        c1_d3_reg <= c1_reg;
        c2_d3_reg <= c2_reg;
        c1_d4_reg <= c1_d3_reg;
        c2_d4_reg <= c2_d3_reg;
        m1_reg    <= m1_next;
        m2_reg    <= m2_next;
        out_reg   <= out_next;
    end

    assign pix_out = out_reg;

endmodule

### rtl/core/depth_keyed_rgba_merge_top.sv
// Depth-keyed RGBA merge of two pixel streams.
// Request channel: drive the two RGBA8 pixels and both 8-bit depths with
// start high; a request is taken at every rising edge where start is high
// and busy is low. busy is always low, so one pixel per clock is taken.
// Result channel: done is high for exactly one cycle with out_red..out_alpha
// valid; the result must be captured in that cycle, there is no back-pressure.
// Each result passes the weight path (depth products, difference, 27x23
// reciprocal multiply, clamp), then the 17x16 interpolation multiplies
// and the final divide-by-255 stage. Throughput: one pixel per clock,
// fully pipelined. Results leave in request order.
// Configuration: APB, registers at 0x0 (overlap reciprocal), 0x4 (depth
// offset), 0x8 and 0xC (depth scales). Write only while no request is in
// flight.
// Reset: asynchronous, active low; clears the pipeline valid bits and loads
// the register reset values. Requests in flight at reset are dropped.
module depth_keyed_rgba_merge_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dkrm_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic [7:0]                   src1_red,
    input  logic [7:0]                   src1_green,
    input  logic [7:0]                   src1_blue,
    input  logic [7:0]                   src1_alpha,
    input  logic [7:0]                   src2_red,
    input  logic [7:0]                   src2_green,
    input  logic [7:0]                   src2_blue,
    input  logic [7:0]                   src2_alpha,
    input  logic [7:0]                   depth_one,
    input  logic [7:0]                   depth_two,
    output logic                         done,
    output logic [7:0]                   out_red,
    output logic [7:0]                   out_green,
    output logic [7:0]                   out_blue,
    output logic [7:0]                   out_alpha
);
    import dkrm_pkg::*;

    localparam int LATENCY = 6;

    cfg_t                cfg;
    rgba_t               pix1, pix2, pix_out;
    logic [16:0]         frac;
    logic [LATENCY-1:0]  vld_reg, vld_next;
    logic                accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign pix1 = {src1_alpha, src1_blue, src1_green, src1_red};
    assign pix2 = {src2_alpha, src2_blue, src2_green, src2_red};

    dkrm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dkrm_weight u_weight (
        .clk       (clk),
        .cfg       (cfg),
        .depth_one (depth_one),
        .depth_two (depth_two),
        .frac      (frac)
    );

    dkrm_comp u_comp (
        .clk     (clk),
        .pix1    (pix1),
        .pix2    (pix2),
        .frac    (frac),
        .pix_out (pix_out)
    );

    assign vld_next = {vld_reg[LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign done      = vld_reg[LATENCY-1];
    assign out_red   = pix_out[0];
    assign out_green = pix_out[1];
    assign out_blue  = pix_out[2];
    assign out_alpha = pix_out[CH_ALPHA];

    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without matching request");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> (frac <= FRAC_ONE))
        else $error("blend weight above one");

    a_opaque_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(src1_alpha == CHAN_MAX && src2_alpha == CHAN_MAX, LATENCY))
        |-> (out_alpha == CHAN_MAX))
        else $error("opaque inputs gave non-opaque alpha");

endmodule

### tb/depth_keyed_rgba_merge_top_tb.sv
module depth_keyed_rgba_merge_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dkrm_pkg::*;

    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int STALL_LIMIT     = 500;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        rgba_t      src1;
        rgba_t      src2;
        logic [7:0] depth_one;
        logic [7:0] depth_two;
    } pixel_req_t;

    class merge_scoreboard;
        rgba_t            expected_px[$];
        logic [INV_W-1:0] inv_overlap;
        int               depth_off;
        int               scale_one;
        int               scale_two;
        int               mismatches;

        function new();
            inv_overlap = INV_RESET;
            depth_off   = int'($signed(OFF_RESET));
            scale_one   = int'($signed(SCALE_RESET));
            scale_two   = int'($signed(SCALE_RESET));
            mismatches  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_INV_OVERLAP: inv_overlap = value[INV_W-1:0];
                REG_DEPTH_OFF:   depth_off   = int'($signed(value[DEPTH_W-1:0]));
                REG_SCALE_ONE:   scale_one   = int'($signed(value[DEPTH_W-1:0]));
                REG_SCALE_TWO:   scale_two   = int'($signed(value[DEPTH_W-1:0]));
                default: ;
            endcase
        endfunction

        // weight in 1/65536 units, 65536 meaning exactly one
        function longint blend_weight(logic [7:0] d1, logic [7:0] d2);
            longint diff;
            longint t;
            diff = longint'(d2) * scale_two
                 - (longint'(d1) * scale_one + longint'(depth_off) * 255);
            t = diff * longint'(inv_overlap) + (longint'(1) <<< 34);
            if (t <= 0)
                return 0;
            t = t >>> 19;
            if (t > longint'(FRAC_ONE))
                t = longint'(FRAC_ONE);
            return t;
        endfunction

        function rgba_t merge_pixel(pixel_req_t p);
            longint frac;
            longint a1;
            longint a2;
            longint c1;
            longint c2;
            longint v;
            rgba_t  res;
            frac = blend_weight(p.depth_one, p.depth_two);
            a1   = longint'(p.src1[CH_ALPHA]);
            a2   = longint'(p.src2[CH_ALPHA]);
            for (int k = 0; k < NUM_CH; k++)
            begin
                c1 = ((k == CH_ALPHA) ? a1 * 255 : a1 * longint'(p.src1[k]))
                   + (255 - a1) * longint'(p.src2[k]);
                c2 = ((k == CH_ALPHA) ? a2 * 255 : a2 * longint'(p.src2[k]))
                   + (255 - a2) * longint'(p.src1[k]);
                if (frac == longint'(FRAC_ONE))
                    v = c1;
                else if (frac == 0)
                    v = c2;
                else
                begin
                    v = (frac * c1 + (longint'(FRAC_ONE) - frac) * c2) >>> 16;
                    if (v > longint'(FULL_SCALE))
                        v = longint'(FULL_SCALE);
                end
                v = (v + v / 256 + 1) / 256;
                if (v > longint'(CHAN_MAX))
                    v = longint'(CHAN_MAX);
                res[k] = 8'(v);
            end
            return res;
        endfunction

        function void note_request(pixel_req_t p);
            expected_px.push_back(merge_pixel(p));
        endfunction

        function void check_result(rgba_t got);
            rgba_t want;
            if (expected_px.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR %0t: merged pixel %h with no request outstanding",
                             $time, got);
                return;
            end
            want = expected_px.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR %0t: RGBA exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                             $time, want[0], want[1], want[2], want[3],
                             got[0], got[1], got[2], got[3]);
            end
        endfunction

        function int pending();
            return expected_px.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              start;
    logic              busy;
    logic [7:0]        src1_red;
    logic [7:0]        src1_green;
    logic [7:0]        src1_blue;
    logic [7:0]        src1_alpha;
    logic [7:0]        src2_red;
    logic [7:0]        src2_green;
    logic [7:0]        src2_blue;
    logic [7:0]        src2_alpha;
    logic [7:0]        depth_one;
    logic [7:0]        depth_two;
    logic              done;
    logic [7:0]        out_red;
    logic [7:0]        out_green;
    logic [7:0]        out_blue;
    logic [7:0]        out_alpha;

    merge_scoreboard   sb;
    int                stall_cycles = 0;

    depth_keyed_rgba_merge_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .src1_red   (src1_red),
        .src1_green (src1_green),
        .src1_blue  (src1_blue),
        .src1_alpha (src1_alpha),
        .src2_red   (src2_red),
        .src2_green (src2_green),
        .src2_blue  (src2_blue),
        .src2_alpha (src2_alpha),
        .depth_one  (depth_one),
        .depth_two  (depth_two),
        .done       (done),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_request({src1_alpha, src1_blue, src1_green, src1_red,
                                 src2_alpha, src2_blue, src2_green, src2_red,
                                 depth_one, depth_two});
            if (done)
                sb.check_result({out_alpha, out_blue, out_green, out_red});
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("depth_keyed_rgba_merge_top verification failed");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic push_pixel(input pixel_req_t p, input bit gaps_on);
        if (gaps_on && $urandom_range(99) < 12)
        begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        {src1_alpha, src1_blue, src1_green, src1_red,
         src2_alpha, src2_blue, src2_green, src2_red,
         depth_one, depth_two} <= p;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // all four registers back to back; spare upper data bits are random
    task automatic program_regs(input logic [31:0] inv_v, input logic [31:0] off_v,
                                input logic [31:0] one_v, input logic [31:0] two_v);
        logic [31:0] vals [NUM_CH];
        logic [31:0] bus;
        vals = '{inv_v, off_v, one_v, two_v};
        for (int i = 0; i < NUM_CH; i++)
        begin
            bus = $urandom;
            if (2'(i) == REG_INV_OVERLAP)
                bus[INV_W-1:0] = vals[i][INV_W-1:0];
            else
                bus[DEPTH_W-1:0] = vals[i][DEPTH_W-1:0];
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {2'(i), 2'b00};
            pwdata  <= bus;
            @(negedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            sb.write_reg(2'(i), bus);
            @(negedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic phase_setting(input int ph, output logic [31:0] inv_v,
                                 output logic [31:0] off_v, output logic [31:0] one_v,
                                 output logic [31:0] two_v);
        case (ph)
            1:  begin inv_v = 0;       off_v = 16384;  one_v = -16384; two_v = 16384;  end
            2:  begin inv_v = 4194303; off_v = -16384; one_v = 16384;  two_v = -16384; end
            3:  begin inv_v = 2056;    off_v = 0;      one_v = 16384;  two_v = 16384;  end
            4:  begin inv_v = 3000;    off_v = 32767;  one_v = -32768; two_v = 32767;  end
            5:  begin inv_v = 1024;    off_v = -32768; one_v = 32767;  two_v = -32768; end
            11: begin inv_v = 32'(INV_RESET); off_v = 0; one_v = 16384; two_v = 16384; end
            default:
            begin
                if ($urandom_range(3) == 0)
                    inv_v = $urandom_range(4112063, 2056);
                else
                    inv_v = $urandom_range(8191, 2056);
                off_v = $urandom_range(32768) - 16384;
                one_v = $urandom_range(32768) - 16384;
                two_v = $urandom_range(32768) - 16384;
            end
        endcase
    endtask

    function automatic pixel_req_t random_pixel();
        pixel_req_t p;
        p.src1      = $urandom;
        p.src2      = $urandom;
        p.depth_one = 8'($urandom);
        p.depth_two = 8'($urandom);
        case ($urandom_range(3))
            1:
            begin
                p.src1[CH_ALPHA] = $urandom_range(1) ? 8'hFF : 8'h00;
                p.src2[CH_ALPHA] = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            2: p.depth_two = p.depth_one + 8'($urandom_range(4)) - 8'd2;
            3: p.depth_two = p.depth_one;
            default: ;
        endcase
        return p;
    endfunction

    initial
    begin
        logic [31:0] inv_v;
        logic [31:0] off_v;
        logic [31:0] one_v;
        logic [31:0] two_v;

        sb         = new();
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        start      = 1'b0;
        {src1_alpha, src1_blue, src1_green, src1_red} = '0;
        {src2_alpha, src2_blue, src2_green, src2_red} = '0;
        depth_one  = '0;
        depth_two  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // colours as {A,B,G,R}; depths decide which source lies in front
        push_pixel({32'h00000000, 32'h00000000, 8'd0,   8'd0},   1'b0);
        push_pixel({32'hFFFFFFFF, 32'hFFFFFFFF, 8'd255, 8'd255}, 1'b0);
        push_pixel({32'hFFFFFFFF, 32'h00000000, 8'd0,   8'd255}, 1'b0);
        push_pixel({32'hFFFFFFFF, 32'h00000000, 8'd255, 8'd0},   1'b0);
        push_pixel({32'hFF0000FF, 32'hFFFF0000, 8'd128, 8'd128}, 1'b0);
        push_pixel({32'h00FFFFFF, 32'h00123456, 8'd0,   8'd0},   1'b0);
        push_pixel({32'hFF204060, 32'hFF80A0C0, 8'd10,  8'd11},  1'b0);
        push_pixel({32'hFF204060, 32'hFF80A0C0, 8'd11,  8'd10},  1'b0);
        push_pixel({32'h80FF8000, 32'h4000FF80, 8'd100, 8'd100}, 1'b0);
        push_pixel({32'h00FFFFFF, 32'hFF000000, 8'd200, 8'd50},  1'b0);
        push_pixel({32'h04030201, 32'hFDFCFBFA, 8'd1,   8'd254}, 1'b0);
        push_pixel({32'h01FFFFFF, 32'hFE000000, 8'd77,  8'd77},  1'b0);
        push_pixel({32'hFFFFFFFF, 32'hFFFFFFFF, 8'd0,   8'd255}, 1'b0);
        push_pixel({32'hAA55AA55, 32'h55AA55AA, 8'd255, 8'd255}, 1'b0);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                wait_drained();
                phase_setting(ph, inv_v, off_v, one_v, two_v);
                program_regs(inv_v, off_v, one_v, two_v);
            end
            // phases 3 and 4 stream without any gap
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                push_pixel(random_pixel(), ph != 3 && ph != 4);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("depth_keyed_rgba_merge_top verification clean");
        else
            $display("depth_keyed_rgba_merge_top verification failed");
        $finish;
    end

endmodule

### depth_keyed_rgba_merge_top.f
rtl/core/dkrm_pkg.sv
rtl/core/dkrm_cfg.sv
rtl/core/dkrm_weight.sv
rtl/core/dkrm_comp.sv
rtl/core/depth_keyed_rgba_merge_top.sv
tb/depth_keyed_rgba_merge_top_tb.sv
